// ----- rtl/assert_macros.svh -----
// Assertion helpers for the decoder RTL, clocked on clock and held off in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("decoder assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("decoder assertion failed");

`endif

// ----- rtl/bin_ad_pkg.sv -----
package bin_ad_pkg;

   localparam int unsigned RANGE_W    = 56;
   localparam int unsigned WORD_W     = 32;
   localparam int unsigned PROB_W     = 12;
   localparam int unsigned SCALE_SH   = 4;
   localparam int unsigned PROD_SH    = 8;
   localparam int unsigned PROD_W     = RANGE_W - SCALE_SH + PROB_W;
   localparam int unsigned TOP_LSB    = RANGE_W - WORD_W;
   localparam int unsigned REQ_DATA_W = 48;
   localparam int unsigned RSP_DATA_W = 16;

   typedef enum logic {
      KIND_DECODE = 1'b0,
      KIND_WORD   = 1'b1
   } kind_type;

   typedef struct packed {
      logic       order_error;
      logic       byte_done;
      logic [7:0] byte_value;
      logic       need_word;
      logic       bit_res;
   } rsp_fields_type;

endpackage

// ----- rtl/binary_arithmetic_decoder_core.sv -----
// Binary arithmetic decoder core.
// Request channel (req_*): each request either decodes one bit (tuser = 0, probability of a
// one in tdata[11:0], in 4096ths) or supplies the next 32-bit code word (tuser = 1, word in
// tdata[43:12]). Every request yields exactly one response on rsp_*: the decoded bit, whether
// a word is owed before the next decode, a completed byte (MSB first) with its done flag, and
// an order error for a decode sent while a word is owed (such a decode is dropped).
// A request goes into one input register, then through the interval split (subtract, one
// 52x12 multiply, add and compare) into the response register.
// One request per clock while rsp_tready is high, set by the combinational interval update.
// When rsp_tready is low the response register holds and the input register can still take
// one more request; req_tready drops only when both are full.
// Reset (synchronous, active high) empties both registers, sets the interval to the full
// range, clears the code and byte state, and leaves two words owed to prime the code register.
`include "assert_macros.svh"

module binary_arithmetic_decoder_core
   import bin_ad_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic                  req_tuser,  // kind
   input  logic [REQ_DATA_W-1:0] req_tdata,  // prob[11:0], word[43:12], zero[47:44]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // bit_res[0], need_word[1], byte_value[9:2], byte_done[10], order_error[11], zero[15:12]
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   logic                in_valid_ff;
   kind_type            kind_ff;
   logic [PROB_W-1:0]   prob_ff;
   logic [WORD_W-1:0]   word_ff;

   logic                rsp_valid_ff;
   rsp_fields_type      rsp_ff, rsp_in;

   logic [RANGE_W-1:0]  low_ff, low_in;
   logic [RANGE_W-1:0]  high_ff, high_in;
   logic [RANGE_W-1:0]  code_ff, code_in;
   logic [1:0]          owed_ff, owed_in;
   logic [6:0]          shift_ff, shift_in;
   logic [2:0]          count_ff, count_in;

   logic                advance;
   logic                owed;
   logic                decode_ok;
   logic                byte_end;
   logic                drop_decode;
   logic [RANGE_W-1:0]  diff;
   logic [PROD_W-1:0]   prod;
   logic [RANGE_W-1:0]  split;
   logic                bit_one;

   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - $bits(rsp_fields_type)){1'b0}}, rsp_ff};

   assign owed        = (owed_ff != 2'd0);
   assign decode_ok   = (kind_ff == KIND_DECODE) && !owed;
   assign byte_end    = advance && decode_ok && (count_ff == 3'd7);
   assign drop_decode = advance && (kind_ff == KIND_DECODE) && owed;

   // interval split: low + (((high - low) >> 4) * prob) >> 8
   assign diff    = high_ff - low_ff;
   assign prod    = {{PROB_W{1'b0}}, diff[RANGE_W-1:SCALE_SH]}
                    * {{(PROD_W - PROB_W){1'b0}}, prob_ff};
   assign split   = low_ff + prod[PROD_SH +: RANGE_W];
   assign bit_one = (code_ff <= split);

   always_comb begin
      low_in   = low_ff;
      high_in  = high_ff;
      code_in  = code_ff;
      owed_in  = owed_ff;
      shift_in = shift_ff;
      count_in = count_ff;
      rsp_in   = '0;
      if (kind_ff == KIND_WORD) begin
         if (owed) begin
            low_in  = {low_ff[TOP_LSB-1:0], {WORD_W{1'b0}}};
            high_in = {high_ff[TOP_LSB-1:0], {WORD_W{1'b1}}};
            code_in = {code_ff[TOP_LSB-1:0], word_ff};
            owed_in = owed_ff - 2'd1;
         end
      end else if (owed) begin
         rsp_in.order_error = 1'b1;
      end else begin
         rsp_in.bit_res = bit_one;
         if (bit_one) begin
            high_in = split;
         end else begin
            low_in = split + {{(RANGE_W-1){1'b0}}, 1'b1};
         end
         if (low_in[RANGE_W-1:TOP_LSB] == high_in[RANGE_W-1:TOP_LSB]) begin
            owed_in = 2'd1;
         end
         if (count_ff == 3'd7) begin
            rsp_in.byte_value = {shift_ff, bit_one};
            rsp_in.byte_done  = 1'b1;
            shift_in          = '0;
            count_in          = '0;
         end else begin
            shift_in = {shift_ff[5:0], bit_one};
            count_in = count_ff + 3'd1;
         end
      end
      rsp_in.need_word = (owed_in != 2'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
      if (req_tready && req_tvalid) begin
         kind_ff <= kind_type'(req_tuser);
         prob_ff <= req_tdata[PROB_W-1:0];
         word_ff <= req_tdata[PROB_W +: WORD_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff   <= '0;
         high_ff  <= '1;
         code_ff  <= '0;
         owed_ff  <= 2'd2;
         shift_ff <= '0;
         count_ff <= '0;
      end else if (advance) begin
         low_ff   <= low_in;
         high_ff  <= high_in;
         code_ff  <= code_in;
         owed_ff  <= owed_in;
         shift_ff <= shift_in;
         count_ff <= count_in;
      end
   end

   // the interval never inverts
   `ASSERT_SAME(a_interval_order, 1'b1, low_ff <= high_ff)
   // the eighth decoded bit of a byte flags a completed byte
   `ASSERT_NEXT(a_byte_done, byte_end, rsp_valid_ff && rsp_ff.byte_done)
   // a dropped decode leaves the interval untouched
   `ASSERT_NEXT(a_error_holds, drop_decode, $stable(low_ff) && $stable(high_ff) && rsp_ff.order_error)
   // an empty input stage always takes a request
   `ASSERT_SAME(a_ready_when_empty, !in_valid_ff, req_tready)

endmodule

// ----- tb/binary_arithmetic_decoder_core_tb.sv -----
module binary_arithmetic_decoder_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import bin_ad_pkg::*;

   localparam real         CLK_PERIOD   = 12.0;
   localparam int unsigned RESET_CYCLES = 9;
   localparam int unsigned CYCLE_LIMIT  = 500000;
   localparam int unsigned DRAIN_CYCLES = 8;
   localparam int unsigned RSP_FIELD_W  = $bits(rsp_fields_type);

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic                  req_tuser  = 1'b0;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   // decoder state as predicted
   logic [RANGE_W-1:0] interval_low;
   logic [RANGE_W-1:0] interval_high;
   logic [RANGE_W-1:0] code_reg;
   logic [1:0]         owed_words;
   logic [6:0]         partial_byte;
   logic [2:0]         byte_bits;

   rsp_fields_type pending_responses[$];
   int unsigned    fail_count      = 0;
   int unsigned    cycle_count     = 0;
   int unsigned    hold_off_cycles = 0;
   bit             tight_send      = 1'b0;

   binary_arithmetic_decoder_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #(CLK_PERIOD / 2.0) clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   function automatic void reset_decoder_state();
      interval_low  = '0;
      interval_high = '1;
      code_reg      = '0;
      owed_words    = 2'd2;
      partial_byte  = '0;
      byte_bits     = '0;
   endfunction

   // Advances the predicted state by one request and returns the response it should give.
   function automatic rsp_fields_type decode_response(input kind_type           kind,
                                                      input logic [PROB_W-1:0] prob,
                                                      input logic [WORD_W-1:0] word);
      rsp_fields_type     rsp;
      logic [RANGE_W-1:0] span;
      logic [RANGE_W-1:0] split;
      logic [63:0]        product;
      rsp = '0;
      if (kind == KIND_WORD) begin
         if (owed_words != 0) begin
            interval_low  = {interval_low[TOP_LSB-1:0], {WORD_W{1'b0}}};
            interval_high = {interval_high[TOP_LSB-1:0], {WORD_W{1'b1}}};
            code_reg      = {code_reg[TOP_LSB-1:0], word};
            owed_words    = owed_words - 2'd1;
         end
      end else if (owed_words != 0) begin
         rsp.order_error = 1'b1;
      end else begin
         span    = interval_high - interval_low;
         product = {8'd0, span >> SCALE_SH} * {52'd0, prob};
         split   = product[PROD_SH +: RANGE_W] + interval_low;
         if (code_reg <= split) begin
            rsp.bit_res   = 1'b1;
            interval_high = split;
         end else begin
            interval_low = split + RANGE_W'(1);
         end
         if (interval_low[RANGE_W-1:TOP_LSB] == interval_high[RANGE_W-1:TOP_LSB])
            owed_words = 2'd1;
         if (byte_bits == 3'd7) begin
            rsp.byte_value = {partial_byte, rsp.bit_res};
            rsp.byte_done  = 1'b1;
            partial_byte   = '0;
            byte_bits      = '0;
         end else begin
            partial_byte = {partial_byte[5:0], rsp.bit_res};
            byte_bits    = byte_bits + 3'd1;
         end
      end
      rsp.need_word = (owed_words != 0);
      return rsp;
   endfunction

   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (tight_send || roll < 60)
         return 0;
      if (roll < 90)
         return $urandom_range(1, 3);
      if (roll < 98)
         return $urandom_range(4, 9);
      return $urandom_range(15, 40);
   endfunction

   function automatic logic [PROB_W-1:0] pick_prob();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 10)
         return '0;
      if (roll < 20)
         return '1;
      if (roll < 40)
         return PROB_W'($urandom_range(1, 15));
      return PROB_W'($urandom_range(0, 4095));
   endfunction

   // Called at a rising edge; leaves tvalid high when the next request follows at once.
   task automatic send_request(input kind_type           kind,
                               input logic [PROB_W-1:0] prob,
                               input logic [WORD_W-1:0] word);
      int unsigned gap;
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {{(REQ_DATA_W - WORD_W - PROB_W){1'b0}}, word, prob};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_responses.push_back(decode_response(kind, prob, word));
      gap = pick_gap();
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Sends whatever the decoder wants next, with the odd out-of-order request mixed in.
   task automatic send_stream_request(input int unsigned noise_pct);
      kind_type kind;
      kind = (owed_words != 0) ? KIND_WORD : KIND_DECODE;
      if ($urandom_range(0, 99) < noise_pct)
         kind = (kind == KIND_WORD) ? KIND_DECODE : KIND_WORD;
      send_request(kind, pick_prob(), $urandom);
   endtask

   task automatic check_field(input string name, input int unsigned want, input int unsigned seen);
      if (want != seen) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $realtime, name, want, seen);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin : check_responses
      rsp_fields_type seen;
      rsp_fields_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen = rsp_tdata[RSP_FIELD_W-1:0];
         if (pending_responses.size() == 0) begin
            $display("%0t: unexpected response, expected none, actual %0h", $realtime, rsp_tdata);
            fail_count++;
         end else begin
            want = pending_responses.pop_front();
            check_field("bit_res", want.bit_res, seen.bit_res);
            check_field("need_word", want.need_word, seen.need_word);
            check_field("byte_value", want.byte_value, seen.byte_value);
            check_field("byte_done", want.byte_done, seen.byte_done);
            check_field("order_error", want.order_error, seen.order_error);
            check_field("tdata padding", 0, rsp_tdata[RSP_DATA_W-1:RSP_FIELD_W]);
         end
      end
   end

   // Receiver: runs of ready, short and long stalls, plus any hold-off a test asks for.
   initial begin : drive_rsp_ready
      int unsigned stall;
      int unsigned ready_run;
      int unsigned roll;
      stall     = 0;
      ready_run = 0;
      forever begin
         @(posedge clock);
         if (hold_off_cycles != 0) begin
            rsp_tready <= 1'b0;
            hold_off_cycles--;
         end else if (stall != 0) begin
            rsp_tready <= 1'b0;
            stall--;
         end else if (ready_run != 0) begin
            rsp_tready <= 1'b1;
            ready_run--;
         end else begin
            roll = $urandom_range(0, 99);
            if (roll < 20) begin
               ready_run = $urandom_range(20, 80);
               rsp_tready <= 1'b1;
            end else if (roll < 50) begin
               stall = (roll < 47) ? $urandom_range(0, 2) : $urandom_range(15, 40);
               rsp_tready <= 1'b0;
            end else begin
               rsp_tready <= 1'b1;
            end
         end
      end
   end

   // Priming, decodes while owed, a surplus word, extreme probabilities and a full byte.
   task automatic test_priming_and_order();
      int unsigned n;
      bit          owed_decode_sent;
      logic [PROB_W-1:0] prob_list[4];
      prob_list        = '{12'd1, 12'd4095, 12'd0, 12'd2048};
      owed_decode_sent = 1'b0;
      send_request(KIND_DECODE, 12'hFFF, 32'h0);
      send_request(KIND_WORD, 12'h0, 32'h0000_0000);
      send_request(KIND_DECODE, 12'h000, 32'h0);
      send_request(KIND_WORD, 12'h0, 32'h0000_0001);
      send_request(KIND_WORD, 12'hABC, 32'hFFFF_FFFF);
      send_request(KIND_DECODE, 12'hFFF, 32'h0);
      send_request(KIND_DECODE, 12'h000, 32'h0);
      for (n = 0; n < 17; n++) begin
         if (owed_words != 0 && !owed_decode_sent) begin
            send_request(KIND_DECODE, 12'h555, 32'h0);
            owed_decode_sent = 1'b1;
         end else if (owed_words != 0) begin
            send_request(KIND_WORD, 12'h0, (n[0]) ? 32'hAAAA_AAAA : 32'h5555_5555);
         end else begin
            send_request(KIND_DECODE, prob_list[n % 4], 32'h0);
         end
      end
   endtask

   // Mostly well-formed streams of random content, with bursts where the sender never idles.
   task automatic test_random_stream();
      int unsigned n;
      for (n = 0; n < 1650; n++) begin
         if (n % 150 == 0)
            tight_send = ($urandom_range(0, 2) == 0);
         send_stream_request(8);
      end
      tight_send = 1'b0;
   endtask

   // Receiver holds off while requests keep coming, so the core fills and stalls its input.
   task automatic test_backpressure();
      int unsigned n;
      tight_send      = 1'b1;
      hold_off_cycles = 150;
      for (n = 0; n < 60; n++)
         send_stream_request(10);
      tight_send = 1'b0;
   endtask

   initial begin
      reset_decoder_state();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      test_priming_and_order();
      test_random_stream();
      test_backpressure();
      req_tvalid <= 1'b0;
      while (pending_responses.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
